// ----- src/rtap_pkg.sv -----
package rtap_pkg;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       end_of_body;
   } req_type;

   typedef struct packed {
      logic [2:0]  kind;
      logic [31:0] value;
      logic [2:0]  char_size;
      logic        element_end;
      logic        body_end;
      logic [2:0]  error_code;
   } rsp_type;

   // result kinds
   localparam logic [2:0] KIND_INT     = 3'd0;
   localparam logic [2:0] KIND_HEADER  = 3'd1;
   localparam logic [2:0] KIND_PAYLOAD = 3'd2;
   localparam logic [2:0] KIND_STR_END = 3'd3;
   localparam logic [2:0] KIND_ERROR   = 3'd4;

   // error codes
   localparam logic [2:0] ERR_NONE      = 3'd0;
   localparam logic [2:0] ERR_BAD_TAG   = 3'd1;
   localparam logic [2:0] ERR_INT_TAG   = 3'd2;
   localparam logic [2:0] ERR_LEN_BYTES = 3'd3;
   localparam logic [2:0] ERR_COUNT     = 3'd4;
   localparam logic [2:0] ERR_TRUNC     = 3'd5;
   localparam logic [2:0] ERR_OVERFLOW  = 3'd6;

   // element tags
   localparam logic [7:0] TAG_INT    = 8'h02;
   localparam logic [7:0] TAG_STR1   = 8'h55;
   localparam logic [7:0] TAG_STR2   = 8'h56;
   localparam logic [7:0] TAG_STR4   = 8'h57;
   localparam logic [3:0] MAX_LEN_BYTES = 4'd4;

endpackage

// ----- src/rtap_parse.sv -----
module rtap_parse
   import rtap_pkg::*;
#(
   parameter int VALUE_WIDTH = 32
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    step,
   input  req_type item,
   output logic    res_valid,
   output rsp_type res
);

   localparam logic [3:0] PH_TAG   = 4'd0;
   localparam logic [3:0] PH_ISIZE = 4'd1;
   localparam logic [3:0] PH_IDATA = 4'd2;
   localparam logic [3:0] PH_SLEN  = 4'd3;
   localparam logic [3:0] PH_SLENB = 4'd4;
   localparam logic [3:0] PH_CTAG  = 4'd5;
   localparam logic [3:0] PH_CSIZE = 4'd6;
   localparam logic [3:0] PH_CDATA = 4'd7;
   localparam logic [3:0] PH_PTAG  = 4'd8;
   localparam logic [3:0] PH_PSIZE = 4'd9;
   localparam logic [3:0] PH_PDATA = 4'd10;
   localparam logic [3:0] PH_PAY   = 4'd11;
   localparam logic [3:0] PH_PAD   = 4'd12;

   localparam logic [34:0] LEN_LIMIT = (VALUE_WIDTH >= 35) ? {35{1'b1}} :
                                       35'((36'd1 << VALUE_WIDTH) - 36'd1);

   logic [3:0]  phase_ff, phase_in;
   logic [31:0] acc_ff, acc_in;
   logic [33:0] left_ff, left_in;
   logic [33:0] payload_ff, payload_in;
   logic [31:0] padding_ff, padding_in;
   logic [31:0] count_ff, count_in;
   logic [1:0]  shift_ff, shift_in;
   logic        latched_ff, latched_in;

   logic [7:0]  b;
   logic        eob;
   logic [2:0]  cs_cur;
   logic [31:0] acc_sh;
   logic [31:0] acc_or;
   logic [33:0] left_dec;
   logic [31:0] raw_len;
   logic [33:0] scaled;
   logic        len_ovf;
   logic [31:0] pad_raw;
   logic [34:0] total;
   logic [2:0]  err;
   logic        emit;

   assign b        = item.data_byte;
   assign eob      = item.end_of_body;
   assign cs_cur   = 3'd1 << shift_ff;
   assign acc_sh   = {acc_ff[23:0], b};
   assign acc_or   = acc_ff | (32'(b) << {count_ff[1:0], 3'b000});
   assign left_dec = left_ff - 34'd1;
   assign raw_len  = (phase_ff == PH_SLENB) ? acc_or : (b[7] ? 32'd0 : {24'd0, b});
   assign scaled   = 34'(raw_len) << shift_ff;
   assign len_ovf  = {1'b0, scaled} > LEN_LIMIT;
   assign pad_raw  = (phase_ff == PH_PSIZE) ? 32'd0 : acc_sh;
   assign total    = 35'(payload_ff) + 35'(pad_raw);

   always_comb begin
      phase_in   = phase_ff;
      acc_in     = acc_ff;
      left_in    = left_ff;
      payload_in = payload_ff;
      padding_in = padding_ff;
      count_in   = count_ff;
      shift_in   = shift_ff;
      latched_in = latched_ff;
      err        = ERR_NONE;
      emit       = 1'b0;
      res        = '{kind: KIND_INT, value: 32'd0, char_size: 3'd1,
                     element_end: 1'b0, body_end: 1'b0, error_code: ERR_NONE};

      if (latched_ff) begin
         // drop bytes until the end of the body
         if (eob) begin
            phase_in   = PH_TAG;
            latched_in = 1'b0;
         end
      end else begin
         unique case (phase_ff)
            PH_ISIZE: begin
               if (b == 8'd0) begin
                  res.element_end = 1'b1;
                  emit            = 1'b1;
                  phase_in        = PH_TAG;
               end else begin
                  left_in  = 34'(b);
                  acc_in   = 32'd0;
                  phase_in = PH_IDATA;
               end
            end
            PH_IDATA, PH_CDATA: begin
               acc_in  = acc_sh;
               left_in = left_dec;
               if (left_dec == 34'd0) begin
                  if (phase_ff == PH_IDATA) begin
                     res.value       = acc_sh;
                     res.element_end = 1'b1;
                     emit            = 1'b1;
                     phase_in        = PH_TAG;
                  end else begin
                     count_in = acc_sh;
                     phase_in = PH_PTAG;
                  end
               end
            end
            PH_SLEN: begin
               if (b[7] && (b[3:0] > MAX_LEN_BYTES)) begin
                  err = ERR_LEN_BYTES;
               end else if (b[7] && (b[3:0] != 4'd0)) begin
                  left_in  = 34'(b[3:0]);
                  acc_in   = 32'd0;
                  count_in = 32'd0;
                  phase_in = PH_SLENB;
               end else if (len_ovf) begin
                  err = ERR_OVERFLOW;
               end else begin
                  payload_in = scaled;
                  phase_in   = PH_CTAG;
               end
            end
            PH_SLENB: begin
               acc_in   = acc_or;
               count_in = count_ff + 32'd1;
               left_in  = left_dec;
               if (left_dec == 34'd0) begin
                  if (len_ovf) begin
                     err = ERR_OVERFLOW;
                  end else begin
                     payload_in = scaled;
                     phase_in   = PH_CTAG;
                  end
               end
            end
            PH_CTAG, PH_PTAG: begin
               if (b == TAG_INT) begin
                  phase_in = (phase_ff == PH_CTAG) ? PH_CSIZE : PH_PSIZE;
               end else begin
                  err = ERR_INT_TAG;
               end
            end
            PH_CSIZE: begin
               if (b == 8'd0) begin
                  count_in = 32'd0;
                  phase_in = PH_PTAG;
               end else begin
                  left_in  = 34'(b);
                  acc_in   = 32'd0;
                  phase_in = PH_CDATA;
               end
            end
            PH_PSIZE, PH_PDATA: begin
               if ((phase_ff == PH_PSIZE) && (b != 8'd0)) begin
                  left_in  = 34'(b);
                  acc_in   = 32'd0;
                  phase_in = PH_PDATA;
               end else begin
                  if (phase_ff == PH_PDATA) begin
                     acc_in  = acc_sh;
                     left_in = left_dec;
                  end
                  if ((phase_ff == PH_PSIZE) || (left_dec == 34'd0)) begin
                     // padding known: check totals and emit the header
                     padding_in = pad_raw;
                     if (total > LEN_LIMIT) begin
                        err = ERR_OVERFLOW;
                     end else if ((count_ff != 32'd0) && !count_ff[31] &&
                                  (35'(count_ff) != total)) begin
                        err = ERR_COUNT;
                     end else begin
                        emit          = 1'b1;
                        res.kind      = KIND_HEADER;
                        res.value     = payload_ff[31:0];
                        res.char_size = cs_cur;
                        if (total == 35'd0) begin
                           res.element_end = 1'b1;
                           phase_in        = PH_TAG;
                        end else if (payload_ff != 34'd0) begin
                           left_in  = payload_ff;
                           phase_in = PH_PAY;
                        end else begin
                           left_in  = 34'(pad_raw);
                           phase_in = PH_PAD;
                        end
                     end
                  end
               end
            end
            PH_PAY: begin
               emit          = 1'b1;
               res.kind      = KIND_PAYLOAD;
               res.value     = 32'(b);
               res.char_size = cs_cur;
               left_in       = left_dec;
               if (left_dec == 34'd0) begin
                  if (padding_ff == 32'd0) begin
                     res.element_end = 1'b1;
                     phase_in        = PH_TAG;
                  end else begin
                     left_in  = 34'(padding_ff);
                     phase_in = PH_PAD;
                  end
               end
            end
            PH_PAD: begin
               left_in = left_dec;
               if (left_dec == 34'd0) begin
                  emit            = 1'b1;
                  res.kind        = KIND_STR_END;
                  res.value       = padding_ff;
                  res.char_size   = cs_cur;
                  res.element_end = 1'b1;
                  phase_in        = PH_TAG;
               end
            end
            default: begin
               // expect element tag; unused codes land here too
               if (b == TAG_INT) begin
                  phase_in = PH_ISIZE;
               end else if ((b == TAG_STR1) || (b == TAG_STR2) || (b == TAG_STR4)) begin
                  shift_in = b[1:0] - 2'd1;
                  phase_in = PH_SLEN;
               end else begin
                  err = ERR_BAD_TAG;
               end
            end
         endcase

         if (err != ERR_NONE) begin
            emit = 1'b1;
            res  = '{kind: KIND_ERROR, value: 32'd0, char_size: 3'd1,
                     element_end: 1'b0, body_end: 1'b0, error_code: err};
            if (eob) begin
               phase_in = PH_TAG;
            end else begin
               latched_in = 1'b1;
            end
         end else if (eob) begin
            if ((phase_in != PH_TAG) || !emit) begin
               emit = 1'b1;
               res  = '{kind: KIND_ERROR, value: 32'd0, char_size: 3'd1,
                        element_end: 1'b0, body_end: 1'b0, error_code: ERR_TRUNC};
            end else begin
               res.body_end = 1'b1;
            end
            phase_in = PH_TAG;
         end
      end
   end

   assign res_valid = step && emit;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PH_TAG;
         latched_ff <= 1'b0;
      end else if (step) begin
         phase_ff   <= phase_in;
         latched_ff <= latched_in;
      end
   end

   always_ff @(posedge clock) begin
      if (step) begin
         acc_ff     <= acc_in;
         left_ff    <= left_in;
         payload_ff <= payload_in;
         padding_ff <= padding_in;
         count_ff   <= count_in;
         shift_ff   <= shift_in;
      end
   end

endmodule

// ----- src/rpc_tlv_argument_parser.sv -----
// Each accepted byte waits in the input register; its result is registered
// in the result register when the byte advances. Throughput: one byte per
// cycle unless a full result register is stalled; the phase update and byte
// shift sit in a single stage between the input and the result register.
// Reset (synchronous, active high) empties both registers and returns the
// parser to expecting an element tag with no error pending.
module rpc_tlv_argument_parser
   import rtap_pkg::*;
#(
   parameter int VALUE_WIDTH = 32
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_item,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_item
);

   logic    in_valid_ff, in_valid_in;
   req_type in_item_ff;
   logic    out_valid_ff, out_valid_in;
   rsp_type out_item_ff;
   logic    advance;
   logic    res_valid;
   rsp_type res;

   // advance when the result register is empty or being taken
   assign advance   = in_valid_ff && (!out_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && !advance;

   rtap_parse #(
      .VALUE_WIDTH(VALUE_WIDTH)
   ) u_parse (
      .clock    (clock),
      .reset    (reset),
      .step     (advance),
      .item     (in_item_ff),
      .res_valid(res_valid),
      .res      (res)
   );

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_valid && !req_stall) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end

      out_valid_in = out_valid_ff;
      if (advance) begin
         out_valid_in = res_valid;
      end else if (out_valid_ff && !rsp_stall) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         in_item_ff <= req_item;
      end
      if (advance && res_valid) begin
         out_item_ff <= res;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_item  = out_item_ff;

endmodule

// ----- tb/rpc_tlv_argument_parser_tb.sv -----
`timescale 1ns / 100ps

module rpc_tlv_argument_parser_tb;
   import rtap_pkg::*;

   localparam int unsigned RAND_ITEMS  = 1350;
   localparam int unsigned HOLD_CYCLES = 200;
   localparam longint unsigned LEN_MAX = 64'hFFFF_FFFF;

   typedef enum logic [3:0] {
      ST_TAG, ST_INT_SIZE, ST_INT_DATA, ST_LEN, ST_LEN_BYTES,
      ST_CNT_TAG, ST_CNT_SIZE, ST_CNT_DATA, ST_PAD_TAG, ST_PAD_SIZE,
      ST_PAD_DATA, ST_PAYLOAD, ST_PADDING
   } parse_state_type;

   typedef struct {
      req_type item;
      bit      typed;
      bit      has;
      rsp_type rsp;
   } dir_row_type;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_item = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_item;

   // predictor state
   parse_state_type parse_st;
   logic [31:0]  acc;
   logic [63:0]  left;
   logic [63:0]  pay_len;
   logic [63:0]  pad_len;
   logic [31:0]  count_seen;
   logic [1:0]   char_sh;
   bit           err_held;

   rsp_type     pending_results[$];
   dir_row_type steps[$];
   logic [7:0]  body_q[$];
   int unsigned mismatches = 0;
   int unsigned fed = 0;
   int unsigned burst_left = 0;
   bit          long_hold_req = 1'b0;

   rpc_tlv_argument_parser u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_item  (req_item),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_item  (rsp_item)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   initial begin
      #20ms;
      $display("Regression FAIL");
      $finish;
   end

   function automatic rsp_type mk_rsp(input logic [2:0] k, input logic [31:0] v,
                                      input logic [2:0] cs, input logic ee,
                                      input logic be, input logic [2:0] code);
      rsp_type r;
      r.kind        = k;
      r.value       = v;
      r.char_size   = cs;
      r.element_end = ee;
      r.body_end    = be;
      r.error_code  = code;
      return r;
   endfunction

   function automatic void parser_clear();
      parse_st   = ST_TAG;
      acc        = '0;
      left       = '0;
      pay_len    = '0;
      pad_len    = '0;
      count_seen = '0;
      char_sh    = '0;
      err_held   = 1'b0;
   endfunction

   function automatic logic [2:0] apply_length(input logic [31:0] raw);
      logic [63:0] scaled;
      scaled = {32'd0, raw} << char_sh;
      if (scaled > LEN_MAX) return ERR_OVERFLOW;
      pay_len  = scaled;
      parse_st = ST_CNT_TAG;
      return ERR_NONE;
   endfunction

   function automatic logic [2:0] close_padding(input logic [31:0] pad, output bit has,
                                                output rsp_type r);
      logic [63:0] total;
      logic [2:0]  cs;
      has     = 1'b0;
      r       = '0;
      cs      = 3'(1 << char_sh);
      pad_len = {32'd0, pad};
      total   = pay_len + pad_len;
      if (total > LEN_MAX) return ERR_OVERFLOW;
      // only a positive count is held against the sizes
      if (count_seen != 0 && !count_seen[31] && {32'd0, count_seen} != total)
         return ERR_COUNT;
      has = 1'b1;
      r   = mk_rsp(KIND_HEADER, pay_len[31:0], cs, total == 0, 1'b0, ERR_NONE);
      if (total == 0) begin
         parse_st = ST_TAG;
      end else if (pay_len != 0) begin
         left     = pay_len;
         parse_st = ST_PAYLOAD;
      end else begin
         left     = pad_len;
         parse_st = ST_PADDING;
      end
      return ERR_NONE;
   endfunction

   function automatic bit parse_byte(input req_type it, output rsp_type r);
      logic [7:0] b;
      logic       eob;
      logic [2:0] err;
      logic [2:0] cs;
      bit         has;
      b   = it.data_byte;
      eob = it.end_of_body;
      err = ERR_NONE;
      has = 1'b0;
      r   = '0;
      // swallow everything up to the end of the body once an error is out
      if (err_held) begin
         if (eob) parser_clear();
         return 1'b0;
      end
      cs = 3'(1 << char_sh);
      case (parse_st)
         ST_TAG: begin
            if (b == TAG_INT) begin
               parse_st = ST_INT_SIZE;
            end else if (b == TAG_STR1 || b == TAG_STR2 || b == TAG_STR4) begin
               char_sh  = 2'(b - TAG_STR1);
               parse_st = ST_LEN;
            end else begin
               err = ERR_BAD_TAG;
            end
         end
         ST_INT_SIZE: begin
            if (b == 8'd0) begin
               has      = 1'b1;
               r        = mk_rsp(KIND_INT, 32'd0, 3'd1, 1'b1, 1'b0, ERR_NONE);
               parse_st = ST_TAG;
            end else begin
               left     = {56'd0, b};
               acc      = '0;
               parse_st = ST_INT_DATA;
            end
         end
         ST_INT_DATA: begin
            acc  = {acc[23:0], b};
            left = left - 1;
            if (left == 0) begin
               has      = 1'b1;
               r        = mk_rsp(KIND_INT, acc, 3'd1, 1'b1, 1'b0, ERR_NONE);
               parse_st = ST_TAG;
            end
         end
         ST_LEN: begin
            if (b[7]) begin
               if (b[3:0] > MAX_LEN_BYTES) begin
                  err = ERR_LEN_BYTES;
               end else if (b[3:0] == 4'd0) begin
                  err = apply_length(32'd0);
               end else begin
                  left       = {60'd0, b[3:0]};
                  acc        = '0;
                  count_seen = '0;
                  parse_st   = ST_LEN_BYTES;
               end
            end else begin
               err = apply_length({24'd0, b});
            end
         end
         ST_LEN_BYTES: begin
            // little-endian length; count_seen tracks the byte position
            acc        = acc | ({24'd0, b} << (8 * count_seen[1:0]));
            count_seen = count_seen + 1;
            left       = left - 1;
            if (left == 0) err = apply_length(acc);
         end
         ST_CNT_TAG, ST_PAD_TAG: begin
            if (b == TAG_INT)
               parse_st = (parse_st == ST_CNT_TAG) ? ST_CNT_SIZE : ST_PAD_SIZE;
            else
               err = ERR_INT_TAG;
         end
         ST_CNT_SIZE: begin
            if (b == 8'd0) begin
               count_seen = '0;
               parse_st   = ST_PAD_TAG;
            end else begin
               left     = {56'd0, b};
               acc      = '0;
               parse_st = ST_CNT_DATA;
            end
         end
         ST_CNT_DATA: begin
            acc  = {acc[23:0], b};
            left = left - 1;
            if (left == 0) begin
               count_seen = acc;
               parse_st   = ST_PAD_TAG;
            end
         end
         ST_PAD_SIZE: begin
            if (b == 8'd0) begin
               err = close_padding(32'd0, has, r);
            end else begin
               left     = {56'd0, b};
               acc      = '0;
               parse_st = ST_PAD_DATA;
            end
         end
         ST_PAD_DATA: begin
            acc  = {acc[23:0], b};
            left = left - 1;
            if (left == 0) err = close_padding(acc, has, r);
         end
         ST_PAYLOAD: begin
            has  = 1'b1;
            left = left - 1;
            if (left == 0 && pad_len == 0) begin
               r        = mk_rsp(KIND_PAYLOAD, {24'd0, b}, cs, 1'b1, 1'b0, ERR_NONE);
               parse_st = ST_TAG;
            end else begin
               r = mk_rsp(KIND_PAYLOAD, {24'd0, b}, cs, 1'b0, 1'b0, ERR_NONE);
               if (left == 0) begin
                  left     = pad_len;
                  parse_st = ST_PADDING;
               end
            end
         end
         default: begin
            left = left - 1;
            if (left == 0) begin
               has      = 1'b1;
               r        = mk_rsp(KIND_STR_END, pad_len[31:0], cs, 1'b1, 1'b0, ERR_NONE);
               parse_st = ST_TAG;
            end
         end
      endcase

      if (err != ERR_NONE) begin
         r = mk_rsp(KIND_ERROR, 32'd0, 3'd1, 1'b0, 1'b0, err);
         if (eob) parser_clear();
         else err_held = 1'b1;
         return 1'b1;
      end
      if (eob) begin
         if (parse_st != ST_TAG || !has) begin
            r   = mk_rsp(KIND_ERROR, 32'd0, 3'd1, 1'b0, 1'b0, ERR_TRUNC);
            has = 1'b1;
         end else begin
            r.body_end = 1'b1;
         end
         parser_clear();
      end
      return has;
   endfunction

   function automatic int unsigned pick_gap();
      int unsigned r;
      if (burst_left > 0) return 0;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 88) return $urandom_range(1, 3);
      if (r < 98) return $urandom_range(4, 10);
      return $urandom_range(20, 40);
   endfunction

   function automatic void add_row(input logic [7:0] b, input logic eob, input bit typed,
                                   input bit has, input rsp_type r);
      dir_row_type row;
      row.item.data_byte   = b;
      row.item.end_of_body = eob;
      row.typed            = typed;
      row.has              = has;
      row.rsp              = r;
      steps.push_back(row);
   endfunction

   function automatic int unsigned bytes_for(input logic [31:0] v);
      if (v == 0) return 0;
      if (v[31:24] != 0) return 4;
      if (v[31:16] != 0) return 3;
      if (v[31:8] != 0) return 2;
      return 1;
   endfunction

   // big-endian integer element, optionally padded with extra leading bytes
   function automatic void push_int(input logic [31:0] v, input int unsigned extra);
      int unsigned sz;
      sz = bytes_for(v) + extra;
      body_q.push_back(TAG_INT);
      body_q.push_back(sz[7:0]);
      for (int i = int'(sz) - 1; i >= 0; i--)
         body_q.push_back((i < 4) ? v[8*i +: 8] : 8'($urandom));
   endfunction

   function automatic void gen_body();
      int unsigned sz, sh, chars, pad, cnt_v, k, total, keep;
      body_q.delete();
      if ($urandom_range(0, 19) == 0) begin
         repeat ($urandom_range(1, 8)) body_q.push_back(8'($urandom));
      end else begin
         repeat ($urandom_range(1, 4)) begin
            if ($urandom_range(0, 1) == 0) begin
               sz = ($urandom_range(0, 99) == 0) ? $urandom_range(7, 255)
                                                 : $urandom_range(0, 6);
               body_q.push_back(TAG_INT);
               body_q.push_back(8'(sz));
               repeat (sz) body_q.push_back(8'($urandom));
            end else begin
               sh = $urandom_range(0, 2);
               body_q.push_back(TAG_STR1 + 8'(sh));
               if ($urandom_range(0, 39) == 0) begin
                  // scaled length or padding sum beyond the value range
                  body_q.push_back(8'h84);
                  repeat (4) body_q.push_back(8'hFF);
                  push_int(32'd0, 0);
                  push_int(32'd1, 0);
               end else begin
                  chars = ($urandom_range(0, 19) == 0) ? $urandom_range(7, 40)
                                                       : $urandom_range(0, 6);
                  pad   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 4);
                  if ($urandom_range(0, 3) != 0) begin
                     body_q.push_back(8'(chars));
                  end else begin
                     k = $urandom_range(bytes_for(chars), 4);
                     if ($urandom_range(0, 29) == 0) k = $urandom_range(5, 15);
                     body_q.push_back({1'b1, 3'($urandom), 4'(k)});
                     for (int i = 0; i < int'(k) && i < 4; i++)
                        body_q.push_back(8'(chars >> (8 * i)));
                  end
                  total = (chars << sh) + pad;
                  case ($urandom_range(0, 9))
                     0:       cnt_v = 0;
                     1:       cnt_v = 32'h8000_0000 | $urandom;
                     2:       cnt_v = total + $urandom_range(1, 3);
                     default: cnt_v = total;
                  endcase
                  push_int(cnt_v, $urandom_range(0, 2));
                  push_int(pad, $urandom_range(0, 2));
                  repeat (total) body_q.push_back(8'($urandom));
               end
            end
         end
      end
      // corrupt or cut a share of the bodies
      if ($urandom_range(0, 9) == 0)
         body_q[$urandom_range(0, body_q.size() - 1)] = 8'($urandom);
      if ($urandom_range(0, 9) == 0) begin
         keep = $urandom_range(1, body_q.size());
         while (body_q.size() > keep) void'(body_q.pop_back());
      end
   endfunction

   task automatic send_byte(input req_type it, input int unsigned gap, input bit typed,
                            input bit typed_has, input rsp_type typed_rsp);
      rsp_type r;
      bit      has;
      repeat (gap) begin
         @(negedge clock);
         req_valid <= 1'b0;
      end
      @(negedge clock);
      req_valid <= 1'b1;
      req_item  <= it;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      has = parse_byte(it, r);
      if (typed) begin
         has = typed_has;
         r   = typed_rsp;
      end
      if (has) pending_results.push_back(r);
   endtask

   task automatic check_field(input string name, input logic [31:0] want,
                              input logic [31:0] got);
      if (want !== got) begin
         $error("%s: expected %0h, got %0h", name, want, got);
         mismatches++;
      end
   endtask

   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_results.size() == 0) begin
            $error("unexpected item: kind %0d value %0h", rsp_item.kind, rsp_item.value);
            mismatches++;
         end else begin
            want = pending_results.pop_front();
            check_field("kind", want.kind, rsp_item.kind);
            check_field("value", want.value, rsp_item.value);
            check_field("char_size", want.char_size, rsp_item.char_size);
            check_field("element_end", want.element_end, rsp_item.element_end);
            check_field("body_end", want.body_end, rsp_item.body_end);
            check_field("error_code", want.error_code, rsp_item.error_code);
         end
      end
   end

   // receiver: runs of ready and stalled cycles, plus one long hold-off on request
   initial begin
      forever begin
         int unsigned r, len;
         bit          val;
         if (long_hold_req) begin
            long_hold_req = 1'b0;
            val = 1'b1;
            len = HOLD_CYCLES;
         end else begin
            r = $urandom_range(0, 99);
            if (r < 50) begin
               val = 1'b0;
               len = $urandom_range(1, 12);
            end else if (r < 62) begin
               val = 1'b0;
               len = $urandom_range(20, 60);
            end else if (r < 92) begin
               val = 1'b1;
               len = $urandom_range(1, 3);
            end else if (r < 98) begin
               val = 1'b1;
               len = $urandom_range(4, 12);
            end else begin
               val = 1'b1;
               len = $urandom_range(20, 40);
            end
         end
         @(negedge clock);
         rsp_stall <= val;
         repeat (len - 1) @(negedge clock);
      end
   end

   initial begin
      req_type it;
      bit      quiet, hold_done, pause_done;
      hold_done  = 1'b0;
      pause_done = 1'b0;
      parser_clear();
      repeat (8) @(negedge clock);
      reset <= 1'b0;

      // integer of size zero
      add_row(TAG_INT, 1'b0, 1'b1, 1'b0, '0);
      add_row(8'h00, 1'b0, 1'b1, 1'b1,
              mk_rsp(KIND_INT, 32'd0, 3'd1, 1'b1, 1'b0, ERR_NONE));
      // five-byte integer: top byte dropped, closes the body
      add_row(TAG_INT, 1'b0, 1'b0, 1'b0, '0);
      add_row(8'h05, 1'b0, 1'b0, 1'b0, '0);
      repeat (4) add_row(8'hFF, 1'b0, 1'b0, 1'b0, '0);
      add_row(8'hFF, 1'b1, 1'b1, 1'b1,
              mk_rsp(KIND_INT, 32'hFFFF_FFFF, 3'd1, 1'b1, 1'b1, ERR_NONE));
      // bad tag, then silence until end of body
      add_row(8'hFF, 1'b0, 1'b1, 1'b1,
              mk_rsp(KIND_ERROR, 32'd0, 3'd1, 1'b0, 1'b0, ERR_BAD_TAG));
      add_row(8'h00, 1'b1, 1'b1, 1'b0, '0);
      // more than four length bytes
      add_row(TAG_STR1, 1'b0, 1'b0, 1'b0, '0);
      add_row(8'h85, 1'b1, 1'b1, 1'b1,
              mk_rsp(KIND_ERROR, 32'd0, 3'd1, 1'b0, 1'b0, ERR_LEN_BYTES));
      // widest long length scaled by four overflows on the end byte
      add_row(TAG_STR4, 1'b0, 1'b0, 1'b0, '0);
      add_row(8'h84, 1'b0, 1'b0, 1'b0, '0);
      repeat (3) add_row(8'hFF, 1'b0, 1'b0, 1'b0, '0);
      add_row(8'hFF, 1'b1, 1'b1, 1'b1,
              mk_rsp(KIND_ERROR, 32'd0, 3'd1, 1'b0, 1'b0, ERR_OVERFLOW));
      // count element without the integer tag
      add_row(TAG_STR2, 1'b0, 1'b0, 1'b0, '0);
      add_row(8'h00, 1'b0, 1'b0, 1'b0, '0);
      add_row(8'h03, 1'b1, 1'b1, 1'b1,
              mk_rsp(KIND_ERROR, 32'd0, 3'd1, 1'b0, 1'b0, ERR_INT_TAG));
      // body cut inside an element
      add_row(TAG_INT, 1'b1, 1'b1, 1'b1,
              mk_rsp(KIND_ERROR, 32'd0, 3'd1, 1'b0, 1'b0, ERR_TRUNC));

      foreach (steps[i])
         send_byte(steps[i].item, pick_gap(), steps[i].typed, steps[i].has, steps[i].rsp);

      while (fed < RAND_ITEMS) begin
         gen_body();
         quiet = ($urandom_range(0, 4) == 0);
         foreach (body_q[i]) begin
            if (!hold_done && fed >= 400) begin
               // stall the output for a long stretch while feeding back to back
               hold_done     = 1'b1;
               long_hold_req = 1'b1;
               burst_left    = 80;
            end
            if (!pause_done && fed >= 800) begin
               pause_done = 1'b1;
               @(negedge clock);
               req_valid <= 1'b0;
               while (pending_results.size() != 0) @(posedge clock);
            end
            fed++;
            it.data_byte   = body_q[i];
            it.end_of_body = (i == body_q.size() - 1);
            send_byte(it, quiet ? 0 : pick_gap(), 1'b0, 1'b0, '0);
            if (burst_left > 0) burst_left--;
         end
      end

      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      if (mismatches == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

endmodule
